// ----- design/dmdrs_pkg.sv -----
`timescale 1ns / 1ps

package dmdrs_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_MOTOR = 2'd1,
    FUNC_LOAD_CAN  = 2'd2,
    FUNC_LOAD_RMT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_DUTY_LIMIT = 2'd0,
    CFG_STEP_UP    = 2'd1,
    CFG_STEP_DOWN  = 2'd2
  } cfg_idx_e;

  localparam int unsigned DutyW  = 16;
  localparam int unsigned LimitW = 15;
  localparam int unsigned StepW  = 10;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgW   = LimitW;

  localparam logic [LimitW-1:0] DutyLimitRst = LimitW'(1000);
  localparam logic [StepW-1:0]  StepUpRst    = StepW'(10);
  localparam logic [StepW-1:0]  StepDownRst  = StepW'(10);

  typedef struct packed {
    logic [LimitW-1:0] duty_limit;
    logic [StepW-1:0]  step_up;
    logic [StepW-1:0]  step_down;
  } cfg_t;

  // Per-motor control from the sequencing logic in the top level.
  typedef struct packed {
    logic load;       // a request is retired this cycle
    logic tick;       // the retired request is a tick
    logic set;        // the retired request sets this motor's target
    logic goal_zero;  // both validity counters have run out
  } motor_ctl_t;

endpackage

// ----- design/dmdrs_in_if.sv -----
`timescale 1ns / 1ps

interface dmdrs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               motor_sel;
  logic signed [15:0] target_duty;
  logic               direction_req;
  logic [15:0]        count_value;

  modport source (output valid, func, motor_sel, target_duty, direction_req, count_value,
                  input ready);
  modport sink (input valid, func, motor_sel, target_duty, direction_req, count_value,
                output ready);
endinterface

// ----- design/dmdrs_out_if.sv -----
`timescale 1ns / 1ps

interface dmdrs_out_if;
  logic               valid;
  logic               ready;
  logic               brake_first;
  logic               brake_second;
  logic signed [15:0] duty_first;
  logic signed [15:0] duty_second;
  logic               dir_first;
  logic               dir_second;

  modport source (output valid, brake_first, brake_second, duty_first, duty_second,
                  dir_first, dir_second, input ready);
  modport sink (input valid, brake_first, brake_second, duty_first, duty_second,
                dir_first, dir_second, output ready);
endinterface

// ----- design/dmdrs_motor.sv -----
`timescale 1ns / 1ps

module dmdrs_motor
  import dmdrs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  motor_ctl_t               ctl_i,
  input  cfg_t                     cfg_i,
  input  logic signed [DutyW-1:0]  target_i,
  input  logic                     dir_req_i,
  output logic                     brake_o,
  output logic signed [DutyW-1:0]  duty_o,
  output logic                     dir_o
);

  logic signed [DutyW-1:0] now_q, now_d;
  logic signed [DutyW-1:0] goal_q, goal_d;
  logic                    app_q, app_d;
  logic                    want_q, want_d;
  logic                    brake_q, brake_d;

  logic signed [DutyW-1:0] goal_dir, goal_valid, goal_clamp;
  logic signed [DutyW:0]   lim_pos, lim_neg;
  logic signed [DutyW:0]   up_sum, down_sum;
  logic signed [DutyW:0]   goal_ext;
  logic                    dir_pending, now_zero;

  always_comb begin
    now_zero    = (now_q == '0);
    dir_pending = (app_q != want_q);

    // A direction change waits for zero duty and meanwhile pulls the target to zero.
    goal_dir   = (dir_pending && !now_zero) ? '0 : goal_q;
    goal_valid = ctl_i.goal_zero ? '0 : goal_dir;

    lim_pos    = $signed({2'b00, cfg_i.duty_limit});
    lim_neg    = -lim_pos;
    goal_ext   = {goal_valid[DutyW-1], goal_valid};
    goal_clamp = ((goal_ext > lim_pos) || (goal_ext < lim_neg)) ? now_q : goal_valid;

    up_sum   = {now_q[DutyW-1], now_q} + $signed({7'b0, cfg_i.step_up});
    down_sum = {now_q[DutyW-1], now_q} - $signed({7'b0, cfg_i.step_down});

    now_d   = now_q;
    goal_d  = goal_q;
    app_d   = app_q;
    want_d  = want_q;
    brake_d = brake_q;

    if (ctl_i.load && ctl_i.tick) begin
      brake_d = now_zero && (goal_q == '0);
      if (dir_pending && now_zero) begin
        app_d = want_q;
      end
      goal_d = goal_clamp;
      if (goal_clamp > now_q) begin
        now_d = (up_sum[DutyW] != up_sum[DutyW-1]) ? 16'sh7fff : up_sum[DutyW-1:0];
      end else if (goal_clamp < now_q) begin
        now_d = (down_sum[DutyW] != down_sum[DutyW-1]) ? 16'sh8000 : down_sum[DutyW-1:0];
      end
    end else if (ctl_i.load && ctl_i.set) begin
      goal_d = target_i;
      want_d = dir_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      goal_q  <= '0;
      app_q   <= 1'b0;
      want_q  <= 1'b0;
      brake_q <= 1'b1;
    end else begin
      now_q   <= now_d;
      goal_q  <= goal_d;
      app_q   <= app_d;
      want_q  <= want_d;
      brake_q <= brake_d;
    end
  end

  assign brake_o = brake_q;
  assign duty_o  = now_q;
  assign dir_o   = app_q;

endmodule

// ----- design/dual_motor_duty_ramp_supervisor_top.sv -----
`timescale 1ns / 1ps
// Flow: a request is registered on acceptance and retired into the motor state once no
// stalled result holds the output; its result is then read from the motor state.
// Throughput: one request per cycle while no result is stalled; the input register lets
// a request be taken while a result waits. Motor state doubles as the result register.
// Reset: asynchronous, active low; duties, targets and counters clear, brakes engage.
module dual_motor_duty_ramp_supervisor_top
  import dmdrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dmdrs_in_if.sink             in_if,
  dmdrs_out_if.source          out_if,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic                    s1_valid_q, s1_valid_d;
  func_e                   s1_func_q;
  logic                    s1_sel_q;
  logic signed [DutyW-1:0] s1_target_q;
  logic                    s1_dir_q;
  logic [CountW-1:0]       s1_count_q;

  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] can_q, can_d;
  logic [CountW-1:0] rmt_q, rmt_d;
  logic              advance, accept, goal_zero, is_tick;
  motor_ctl_t        ctl_first, ctl_second;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DUTY_LIMIT: cfg_d.duty_limit = cfg_data_i;
        CFG_STEP_UP:    cfg_d.step_up    = cfg_data_i[StepW-1:0];
        CFG_STEP_DOWN:  cfg_d.step_down  = cfg_data_i[StepW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;
  assign accept      = in_if.valid && in_if.ready;
  assign s1_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);

  assign goal_zero = (can_q == '0) && (rmt_q == '0);
  assign is_tick   = (s1_func_q == FUNC_TICK);

  // The CAN count runs down first; the remote count only once the CAN count is spent.
  always_comb begin
    can_d = can_q;
    rmt_d = rmt_q;
    if (advance) begin
      case (s1_func_q)
        FUNC_TICK: begin
          if (can_q != '0) begin
            can_d = can_q - 1'b1;
          end else if (rmt_q != '0) begin
            rmt_d = rmt_q - 1'b1;
          end
        end
        FUNC_LOAD_CAN:  can_d = s1_count_q;
        FUNC_LOAD_RMT:  rmt_d = s1_count_q;
        default:        can_d = can_q;
      endcase
    end
  end

  always_comb begin
    ctl_first.load       = advance;
    ctl_first.tick       = is_tick;
    ctl_first.set        = (s1_func_q == FUNC_SET_MOTOR) && !s1_sel_q;
    ctl_first.goal_zero  = goal_zero;
    ctl_second.load      = advance;
    ctl_second.tick      = is_tick;
    ctl_second.set       = (s1_func_q == FUNC_SET_MOTOR) && s1_sel_q;
    ctl_second.goal_zero = goal_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_limit <= DutyLimitRst;
      cfg_q.step_up    <= StepUpRst;
      cfg_q.step_down  <= StepDownRst;
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      can_q            <= '0;
      rmt_q            <= '0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      can_q       <= can_d;
      rmt_q       <= rmt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= func_e'(in_if.func);
      s1_sel_q    <= in_if.motor_sel;
      s1_target_q <= in_if.target_duty;
      s1_dir_q    <= in_if.direction_req;
      s1_count_q  <= in_if.count_value;
    end
  end

  dmdrs_motor u_motor_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_first),
    .cfg_i     (cfg_q),
    .target_i  (s1_target_q),
    .dir_req_i (s1_dir_q),
    .brake_o   (out_if.brake_first),
    .duty_o    (out_if.duty_first),
    .dir_o     (out_if.dir_first)
  );

  dmdrs_motor u_motor_second (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_second),
    .cfg_i     (cfg_q),
    .target_i  (s1_target_q),
    .dir_req_i (s1_dir_q),
    .brake_o   (out_if.brake_second),
    .duty_o    (out_if.duty_second),
    .dir_o     (out_if.dir_second)
  );

  assign out_if.valid = out_valid_q;

endmodule

// ----- design/dmdrs_checker.sv -----
`timescale 1ns / 1ps

module dmdrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        brake_first_i,
  input logic        brake_second_i,
  input logic [15:0] duty_first_i,
  input logic [15:0] duty_second_i
);

  // A stalled result keeps its duties.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(duty_first_i)
                                    && $stable(duty_second_i))
    else $error("result changed while stalled");

  // Requests are refused only when a result is waiting and stalled.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output back-pressure");

  // An engaged brake means the motor was at rest with a zero target, so it stays at rest.
  a_brake_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && brake_first_i |-> duty_first_i == 16'h0000)
    else $error("first motor moving with brake engaged");

  a_brake_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && brake_second_i |-> duty_second_i == 16'h0000)
    else $error("second motor moving with brake engaged");

endmodule

bind dual_motor_duty_ramp_supervisor_top dmdrs_checker u_dmdrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .brake_first_i  (out_if.brake_first),
  .brake_second_i (out_if.brake_second),
  .duty_first_i   (out_if.duty_first),
  .duty_second_i  (out_if.duty_second)
);

// ----- tb/tb_dual_motor_duty_ramp_supervisor_top.sv -----
`timescale 1ns / 1ps

module tb_dual_motor_duty_ramp_supervisor_top;
  import dmdrs_pkg::*;

  // The index after the last register; a write to it must change nothing.
  localparam logic [1:0] CfgIdxUnused = 2'd3;
  localparam int RandomPerPhase = 106;
  localparam int ShownMismatches = 10;

  typedef struct packed {
    logic                    brake_first;
    logic                    brake_second;
    logic signed [DutyW-1:0] duty_first;
    logic signed [DutyW-1:0] duty_second;
    logic                    dir_first;
    logic                    dir_second;
  } motor_report_t;

  class duty_ramp_scoreboard;
    logic [LimitW-1:0]       limit;
    logic [StepW-1:0]        inc;
    logic [StepW-1:0]        dec;
    logic signed [DutyW-1:0] duty_act [2];
    logic signed [DutyW-1:0] duty_tgt [2];
    logic                    rot_applied [2];
    logic                    rot_wanted [2];
    logic                    brake_on [2];
    logic [CountW-1:0]       can_left;
    logic [CountW-1:0]       remote_left;
    motor_report_t           expected_reports [$];
    int                      errors;

    function new();
      limit = DutyLimitRst;
      inc = StepUpRst;
      dec = StepDownRst;
      for (int m = 0; m < 2; m++) begin
        duty_act[m] = '0;
        duty_tgt[m] = '0;
        rot_applied[m] = 1'b0;
        rot_wanted[m] = 1'b0;
        brake_on[m] = 1'b1;
      end
      can_left = '0;
      remote_left = '0;
      errors = 0;
    endfunction

    function void configure(input logic [1:0] idx, input logic [CfgW-1:0] data);
      case (idx)
        CFG_DUTY_LIMIT: limit = data[LimitW-1:0];
        CFG_STEP_UP:    inc = data[StepW-1:0];
        CFG_STEP_DOWN:  dec = data[StepW-1:0];
        default: ;
      endcase
    endfunction

    function void ramp_tick();
      int lim;
      int d;
      int g;
      lim = int'(limit);
      // Brakes are judged on the state before this tick.
      for (int m = 0; m < 2; m++) begin
        brake_on[m] = (duty_act[m] == '0) && (duty_tgt[m] == '0);
      end
      for (int m = 0; m < 2; m++) begin
        if (rot_applied[m] != rot_wanted[m]) begin
          if (duty_act[m] == '0) rot_applied[m] = rot_wanted[m];
          else duty_tgt[m] = '0;
        end
      end
      if (can_left == '0 && remote_left == '0) begin
        duty_tgt[0] = '0;
        duty_tgt[1] = '0;
      end else if (can_left != '0) begin
        can_left = can_left - CountW'(1);
      end else begin
        remote_left = remote_left - CountW'(1);
      end
      for (int m = 0; m < 2; m++) begin
        d = int'(duty_act[m]);
        g = int'(duty_tgt[m]);
        if (g > lim || g < -lim) begin
          g = d;
          duty_tgt[m] = duty_act[m];
        end
        if (g > d) d = d + int'(inc);
        else if (g < d) d = d - int'(dec);
        if (d > 32767) d = 32767;
        else if (d < -32768) d = -32768;
        duty_act[m] = 16'(d);
      end
    endfunction

    function void note_request(input func_e f, input logic sel,
                               input logic signed [DutyW-1:0] tgt, input logic dir,
                               input logic [CountW-1:0] cnt);
      motor_report_t rep;
      case (f)
        FUNC_TICK: ramp_tick();
        FUNC_SET_MOTOR: begin
          duty_tgt[sel] = tgt;
          rot_wanted[sel] = dir;
        end
        FUNC_LOAD_CAN: can_left = cnt;
        default: remote_left = cnt;
      endcase
      rep.brake_first = brake_on[0];
      rep.brake_second = brake_on[1];
      rep.duty_first = duty_act[0];
      rep.duty_second = duty_act[1];
      rep.dir_first = rot_applied[0];
      rep.dir_second = rot_applied[1];
      expected_reports.push_back(rep);
    endfunction

    function void check_report(input motor_report_t got);
      motor_report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= ShownMismatches)
          $display("unexpected report: brake %b/%b duty %0d/%0d dir %b/%b",
                   got.brake_first, got.brake_second, got.duty_first, got.duty_second,
                   got.dir_first, got.dir_second);
        return;
      end
      want = expected_reports.pop_front();
      if (got.brake_first !== want.brake_first || got.brake_second !== want.brake_second ||
          got.duty_first !== want.duty_first || got.duty_second !== want.duty_second ||
          got.dir_first !== want.dir_first || got.dir_second !== want.dir_second) begin
        errors++;
        if (errors <= ShownMismatches) begin
          $display("mismatch: expected brake %b/%b duty %0d/%0d dir %b/%b",
                   want.brake_first, want.brake_second, want.duty_first, want.duty_second,
                   want.dir_first, want.dir_second);
          $display("          actual   brake %b/%b duty %0d/%0d dir %b/%b",
                   got.brake_first, got.brake_second, got.duty_first, got.duty_second,
                   got.dir_first, got.dir_second);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;

  int                send_idle_pct;
  int                recv_stall_pct;
  int                cur_limit;
  logic              want_dir [2];
  duty_ramp_scoreboard board;

  dmdrs_in_if  in_bus ();
  dmdrs_out_if out_bus ();

  dual_motor_duty_ramp_supervisor_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_bus),
    .out_if     (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= 32'(recv_stall_pct));
  end

  // Both handshakes are sampled here, on values from before the edge.
  always @(posedge clk_i) begin
    motor_report_t seen;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        board.note_request(func_e'(in_bus.func), in_bus.motor_sel, in_bus.target_duty,
                           in_bus.direction_req, in_bus.count_value);
      if (out_bus.valid && out_bus.ready) begin
        seen.brake_first = out_bus.brake_first;
        seen.brake_second = out_bus.brake_second;
        seen.duty_first = out_bus.duty_first;
        seen.duty_second = out_bus.duty_second;
        seen.dir_first = out_bus.dir_first;
        seen.dir_second = out_bus.dir_second;
        board.check_report(seen);
      end
    end
  end

  task automatic issue_request(input func_e f, input logic sel,
                               input logic signed [DutyW-1:0] tgt, input logic dir,
                               input logic [CountW-1:0] cnt);
    while ($urandom_range(99) < 32'(send_idle_pct)) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= f;
    in_bus.motor_sel <= sel;
    in_bus.target_duty <= tgt;
    in_bus.direction_req <= dir;
    in_bus.count_value <= cnt;
    if (f == FUNC_SET_MOTOR) want_dir[sel] = dir;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic issue_tick();
    issue_request(FUNC_TICK, 1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic issue_random_request();
    int pick;
    int shape;
    logic sel;
    logic dir;
    logic signed [DutyW-1:0] tgt;
    logic [CountW-1:0] cnt;
    pick = int'($urandom_range(99));
    sel = 1'($urandom);
    // Mostly keep the wanted direction, otherwise that motor's target is held at zero until its duty reaches zero.
    dir = ($urandom_range(7) == 0) ? ~want_dir[sel] : want_dir[sel];
    shape = int'($urandom_range(99));
    if (shape < 70) begin
      tgt = 16'(int'($urandom_range(2 * cur_limit)) - cur_limit);
    end else if (shape < 85) begin
      tgt = 16'($urandom);
    end else begin
      case ($urandom_range(5))
        0: tgt = 16'sh7FFF;
        1: tgt = 16'sh8000;
        2: tgt = '0;
        3: tgt = 16'(cur_limit);
        4: tgt = 16'(-cur_limit);
        default: tgt = 16'(cur_limit + 1);
      endcase
    end
    shape = int'($urandom_range(9));
    if (shape < 8) cnt = 16'($urandom_range(40, 1));
    else if (shape < 9) cnt = '0;
    else cnt = 16'($urandom);
    if (pick < 50) issue_tick();
    else if (pick < 80) issue_request(FUNC_SET_MOTOR, sel, tgt, dir, cnt);
    else if (pick < 90) issue_request(FUNC_LOAD_CAN, sel, tgt, dir, cnt);
    else issue_request(FUNC_LOAD_RMT, sel, tgt, dir, cnt);
  endtask

  task automatic wait_for_reports();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.configure(idx, data);
  endtask

  task automatic configure_phase(input logic [CfgW-1:0] lim, input logic [CfgW-1:0] up,
                                 input logic [CfgW-1:0] dn);
    write_reg(CFG_DUTY_LIMIT, lim);
    write_reg(CFG_STEP_UP, up);
    write_reg(CFG_STEP_DOWN, dn);
    cfg_we_i <= 1'b0;
    cur_limit = int'(lim);
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_TICK;
    in_bus.motor_sel = 1'b0;
    in_bus.target_duty = '0;
    in_bus.direction_req = 1'b0;
    in_bus.count_value = '0;
    out_bus.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_limit = int'(DutyLimitRst);
    want_dir[0] = 1'b0;
    want_dir[1] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings. A tick with no validity left keeps both motors braked.
    issue_request(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, 16'h0000);
    issue_request(FUNC_LOAD_CAN, 1'b1, 16'sh7FFF, 1'b1, 16'hFFFF);
    issue_request(FUNC_LOAD_RMT, 1'b0, 16'sh8000, 1'b0, 16'h0003);
    // Targets beyond the limit fall back to the present duty; motor two turns round at rest.
    issue_request(FUNC_SET_MOTOR, 1'b0, 16'sh7FFF, 1'b0, 16'h0000);
    issue_request(FUNC_SET_MOTOR, 1'b1, 16'sh8000, 1'b1, 16'hFFFF);
    repeat (2) issue_tick();
    issue_request(FUNC_SET_MOTOR, 1'b0, 16'sd1000, 1'b0, 16'h0000);
    issue_request(FUNC_SET_MOTOR, 1'b1, -16'sd1000, 1'b1, 16'h0000);
    repeat (3) issue_tick();
    issue_request(FUNC_SET_MOTOR, 1'b0, 16'sd1001, 1'b0, 16'h0000);
    issue_tick();
    // Reversal requested while turning: the target is dropped until the duty reaches zero.
    issue_request(FUNC_SET_MOTOR, 1'b0, 16'sd500, 1'b1, 16'h0000);
    repeat (3) issue_tick();
    // CAN validity gone; the remote count runs down, then every target is zeroed.
    issue_request(FUNC_LOAD_CAN, 1'b0, 16'sh0000, 1'b0, 16'h0000);
    issue_request(FUNC_SET_MOTOR, 1'b1, -16'sd1001, 1'b1, 16'h0000);
    repeat (5) issue_tick();

    wait_for_reports();
    configure_phase(15'h7FFF, 15'd1023, 15'd1023);
    // Drive both motors into the rails with the widest steps.
    issue_request(FUNC_LOAD_CAN, 1'b0, 16'sh0000, 1'b0, 16'd200);
    issue_request(FUNC_SET_MOTOR, 1'b0, 16'sh7FFF, board.rot_applied[0], 16'h0000);
    issue_request(FUNC_SET_MOTOR, 1'b1, -16'sh7FFF, board.rot_applied[1], 16'h0000);
    repeat (40) issue_tick();
    repeat (RandomPerPhase) issue_random_request();

    wait_for_reports();
    send_idle_pct = 59;
    configure_phase(15'd0, 15'd1, 15'd1);
    repeat (RandomPerPhase) issue_random_request();

    wait_for_reports();
    send_idle_pct = 0;
    recv_stall_pct = 59;
    // Only the low bits of a step register are kept, so the step down is zero here.
    configure_phase(15'($urandom_range(5000, 200)), 15'($urandom_range(1023, 1)), 15'h7C00);
    repeat (RandomPerPhase) issue_random_request();

    wait_for_reports();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    configure_phase(15'($urandom_range(32767)), {5'b10110, 10'($urandom_range(1023, 1))},
                    15'($urandom_range(1023, 1)));
    repeat (RandomPerPhase) issue_random_request();

    wait_for_reports();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CfgIdxUnused, 15'h7FFF);
    configure_phase(15'($urandom_range(3000, 1)), 15'($urandom_range(64, 1)),
                    15'($urandom_range(64, 1)));
    repeat (RandomPerPhase) issue_random_request();

    wait_for_reports();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
